// ----- rtl/tts_pkg.sv -----
`timescale 1ns / 1ps

package tts_pkg;

    // Stream payload widths
    localparam int DATA_W = 64;
    localparam int OP_W   = 2;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int PDATA_W = 32;

    // Shared multiply-accumulate unit
    localparam int MAC_A_W = 32;
    localparam int MAC_B_W = 24;
    localparam int MAC_P_W = MAC_A_W + MAC_B_W;
    localparam int ACC_W   = 75;
    localparam int HI_W    = ACC_W - MAC_A_W;

    // Item kinds carried in tuser
    localparam logic [OP_W-1:0] OP_CUR    = 2'd0;
    localparam logic [OP_W-1:0] OP_STORED = 2'd1;
    localparam logic [OP_W-1:0] OP_EOF    = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_MIN_AREA = 2'd0;
    localparam logic [1:0] REG_CENTER_X = 2'd1;
    localparam logic [1:0] REG_CENTER_Y = 2'd2;

    // Register reset values
    localparam logic [23:0] MIN_AREA_RST = 24'd0;
    localparam logic [11:0] CENTER_X_RST = 12'd320;
    localparam logic [11:0] CENTER_Y_RST = 12'd240;

    // One box; id sits in the lowest bits of the packed word
    typedef struct packed {
        logic [11:0] h;
        logic [11:0] w;
        logic [11:0] y;
        logic [11:0] x;
        logic [15:0] id;
    } box_t;

    typedef struct packed {
        logic [23:0] min_area;
        logic [11:0] center_x;
        logic [11:0] center_y;
    } cfg_t;

    // Command to the multiply-accumulate unit
    typedef struct packed {
        logic [MAC_A_W-1:0] a;
        logic [MAC_B_W-1:0] b;
        logic               hi;     // product weighted by 2^32
        logic               accum;  // add to accumulator instead of load
    } mac_cmd_t;

endpackage

// ----- rtl/tracked_target_selector_core.sv -----
`timescale 1ns / 1ps
// The single shared multiply-accumulate unit forms the area, the squared distance and both
// 75-bit cross products in turn, so a new box is taken only once the last is through. A
// current-frame box stops after its area if too small, after its distance if it is the first
// candidate, else after both cross products and the compare with the best. A stored box
// is taken in idle; an end-of-frame beat waits while an earlier result is held.
// Reset: rst_n clears the tracking, the per-frame state and the registers to their defaults.

module tracked_target_selector_core
    import tts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Input stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [DATA_W-1:0]  s_tdata,   // box_id[15:0], box_x, box_y, box_width, box_height
    input  logic [OP_W-1:0]    s_tuser,   // op[1:0]
    // Output stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // chosen_id[15:0], chosen_x, chosen_y,
                                          // chosen_width, chosen_height
    output logic               m_tuser    // found
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_AREA = 4'd1;
    localparam logic [3:0] S_DX   = 4'd2;
    localparam logic [3:0] S_DY   = 4'd3;
    localparam logic [3:0] S_DSQ  = 4'd4;
    localparam logic [3:0] S_N1   = 4'd5;
    localparam logic [3:0] S_N2   = 4'd6;
    localparam logic [3:0] S_B0   = 4'd7;
    localparam logic [3:0] S_B1   = 4'd8;
    localparam logic [3:0] S_B2   = 4'd9;
    localparam logic [3:0] S_CMP  = 4'd10;
    localparam logic [3:0] S_EOF  = 4'd11;

    cfg_t             cfg;
    mac_cmd_t         mac_cmd;
    logic [ACC_W-1:0] acc;

    logic [3:0]   state_reg;
    logic [3:0]   state_next;
    logic         tracking_valid_reg;
    logic [15:0]  tracked_id_reg;
    logic         frame_nonempty_reg;
    logic         match_seen_reg;
    logic         stored_match_seen_reg;
    logic         best_valid_reg;
    logic         m_tvalid_reg;

    box_t         box_reg;
    box_t         match_box_reg;
    box_t         best_box_reg;
    box_t         out_box_reg;
    logic [26:0]  best_dsq_reg;
    logic [23:0]  best_area_reg;
    logic [23:0]  area_reg;
    logic [26:0]  dsq_reg;
    logic [ACC_W-1:0] n_reg;
    logic [HI_W-MAC_A_W+MAC_A_W-MAC_B_W-1:0] thi_reg;

    box_t         in_box;
    logic         s_accept;
    logic         id_hit;
    logic         out_free;
    logic         result_due;
    logic         area_ok;
    logic         take;
    logic [12:0]  ctr_x;
    logic [12:0]  ctr_y;
    logic [13:0]  dx;
    logic [13:0]  dy;
    logic [12:0]  abs_dx;
    logic [12:0]  abs_dy;

    tts_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tts_mac u_mac (
        .clk (clk),
        .cmd (mac_cmd),
        .acc (acc)
    );

    assign in_box   = box_t'(s_tdata);
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign id_hit   = tracking_valid_reg && (in_box.id == tracked_id_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign area_ok  = acc[23:0] > cfg.min_area;
    assign take     = n_reg < acc;
    assign result_due = frame_nonempty_reg &&
                        (match_seen_reg || (!stored_match_seen_reg && best_valid_reg));

    // Offset of the box center from the frame center
    always_comb
    begin
        ctr_x  = {1'b0, box_reg.x} + {2'b0, box_reg.w[11:1]};
        ctr_y  = {1'b0, box_reg.y} + {2'b0, box_reg.h[11:1]};
        dx     = {2'b0, cfg.center_x} - {1'b0, ctr_x};
        dy     = {2'b0, cfg.center_y} - {1'b0, ctr_y};
        abs_dx = dx[13] ? 13'(-dx) : dx[12:0];
        abs_dy = dy[13] ? 13'(-dy) : dy[12:0];
    end

    // Drive the shared unit for each step
    always_comb
    begin
        mac_cmd.a     = {20'd0, box_reg.w};
        mac_cmd.b     = {12'd0, box_reg.h};
        mac_cmd.hi    = 1'b0;
        mac_cmd.accum = 1'b0;
        case (state_reg)
            S_DX:
            begin
                mac_cmd.a = {19'd0, abs_dx};
                mac_cmd.b = {11'd0, abs_dx};
            end
            S_DY:
            begin
                mac_cmd.a     = {19'd0, abs_dy};
                mac_cmd.b     = {11'd0, abs_dy};
                mac_cmd.accum = 1'b1;
            end
            S_DSQ:
            begin
                mac_cmd.a = {5'd0, acc[26:0]};
                mac_cmd.b = best_area_reg;
            end
            S_N1:
            begin
                mac_cmd.a = acc[MAC_A_W-1:0];
                mac_cmd.b = best_area_reg;
            end
            S_N2:
            begin
                mac_cmd.a     = {13'd0, thi_reg};
                mac_cmd.b     = best_area_reg;
                mac_cmd.hi    = 1'b1;
                mac_cmd.accum = 1'b1;
            end
            S_B0:
            begin
                mac_cmd.a = {5'd0, best_dsq_reg};
                mac_cmd.b = area_reg;
            end
            S_B1:
            begin
                mac_cmd.a = acc[MAC_A_W-1:0];
                mac_cmd.b = area_reg;
            end
            S_B2:
            begin
                mac_cmd.a     = {13'd0, thi_reg};
                mac_cmd.b     = area_reg;
                mac_cmd.hi    = 1'b1;
                mac_cmd.accum = 1'b1;
            end
            default: ;
        endcase
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (s_tuser)
                        OP_CUR:  state_next = S_AREA;
                        OP_EOF:  state_next = S_EOF;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_AREA: state_next = S_DX;
            S_DX:   state_next = area_ok ? S_DY : S_IDLE;
            S_DY:   state_next = S_DSQ;
            S_DSQ:  state_next = best_valid_reg ? S_N1 : S_IDLE;
            S_N1:   state_next = S_N2;
            S_N2:   state_next = S_B0;
            S_B0:   state_next = S_B1;
            S_B1:   state_next = S_B2;
            S_B2:   state_next = S_CMP;
            S_CMP:  state_next = S_IDLE;
            S_EOF:  state_next = out_free ? S_IDLE : S_EOF;
            default: state_next = S_IDLE;
        endcase
    end

    // Control state: tracking, per-frame flags, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= S_IDLE;
            tracking_valid_reg    <= 1'b0;
            tracked_id_reg        <= '0;
            frame_nonempty_reg    <= 1'b0;
            match_seen_reg        <= 1'b0;
            stored_match_seen_reg <= 1'b0;
            best_valid_reg        <= 1'b0;
            m_tvalid_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // Raise the result beat at end of frame, drop it once taken
            if ((state_reg == S_EOF) && out_free && result_due)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_accept)
                    begin
                        case (s_tuser)
                            OP_CUR:
                            begin
                                frame_nonempty_reg <= 1'b1;
                                if (id_hit)
                                    match_seen_reg <= 1'b1;
                            end
                            OP_STORED:
                            begin
                                if (id_hit)
                                    stored_match_seen_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DSQ:
                begin
                    best_valid_reg <= 1'b1;
                end
                S_EOF:
                begin
                    if (out_free)
                    begin
                        if (frame_nonempty_reg && !match_seen_reg &&
                            !stored_match_seen_reg && best_valid_reg)
                        begin
                            tracking_valid_reg <= 1'b1;
                            tracked_id_reg     <= best_box_reg.id;
                        end
                        frame_nonempty_reg    <= 1'b0;
                        match_seen_reg        <= 1'b0;
                        stored_match_seen_reg <= 1'b0;
                        best_valid_reg        <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: boxes, intermediate products, output beat
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (s_accept && (s_tuser == OP_CUR))
                begin
                    box_reg <= in_box;
                    if (id_hit && !match_seen_reg)
                        match_box_reg <= in_box;
                end
            end
            S_DX:
            begin
                area_reg <= acc[23:0];
            end
            S_DSQ:
            begin
                dsq_reg <= acc[26:0];
                if (!best_valid_reg)
                begin
                    best_box_reg  <= box_reg;
                    best_dsq_reg  <= acc[26:0];
                    best_area_reg <= area_reg;
                end
            end
            S_N1:
            begin
                thi_reg <= acc[50:MAC_A_W];
            end
            S_B0:
            begin
                n_reg <= acc;
            end
            S_B1:
            begin
                thi_reg <= acc[50:MAC_A_W];
            end
            S_CMP:
            begin
                // Replace the best only on a strictly smaller ratio
                if (take)
                begin
                    best_box_reg  <= box_reg;
                    best_dsq_reg  <= dsq_reg;
                    best_area_reg <= area_reg;
                end
            end
            S_EOF:
            begin
                if (out_free)
                    out_box_reg <= match_seen_reg ? match_box_reg : best_box_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_box_reg;
    // Every emitted beat reports a found target
    assign m_tuser  = 1'b1;

`ifndef ASSERT_OFF
    a_out_from_eof: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_EOF))
        else $error("result beat raised outside end-of-frame step");

    a_best_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        best_valid_reg |-> frame_nonempty_reg)
        else $error("best candidate held in an empty frame");

    a_match_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        match_seen_reg |-> tracking_valid_reg)
        else $error("match seen with nothing tracked");

    a_id_at_eof: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(tracked_id_reg) |-> $past(state_reg == S_EOF))
        else $error("tracked id changed outside end-of-frame step");
`endif

endmodule

// ----- rtl/tts_cfg.sv -----
`timescale 1ns / 1ps

module tts_cfg
    import tts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_area <= MIN_AREA_RST;
            cfg_reg.center_x <= CENTER_X_RST;
            cfg_reg.center_y <= CENTER_Y_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_AREA: cfg_reg.min_area <= pwdata[23:0];
                REG_CENTER_X: cfg_reg.center_x <= pwdata[11:0];
                REG_CENTER_Y: cfg_reg.center_y <= pwdata[11:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            REG_MIN_AREA: prdata = {8'd0, cfg_reg.min_area};
            REG_CENTER_X: prdata = {20'd0, cfg_reg.center_x};
            REG_CENTER_Y: prdata = {20'd0, cfg_reg.center_y};
            default:      prdata = '0;
        endcase
    end

endmodule

// ----- rtl/tts_mac.sv -----
`timescale 1ns / 1ps

module tts_mac
    import tts_pkg::*;
(
    input  logic             clk,
    input  mac_cmd_t         cmd,
    output logic [ACC_W-1:0] acc
);

    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [MAC_P_W-1:0] prod;
    logic [ACC_W-1:0]   term;

    // Multiply, align the partial product, then load or accumulate
    always_comb
    begin
        prod = cmd.a * cmd.b;
        if (cmd.hi)
            term = {prod[HI_W-1:0], {MAC_A_W{1'b0}}};
        else
            term = {{(ACC_W-MAC_P_W){1'b0}}, prod};
        if (cmd.accum)
            acc_next = acc_reg + term;
        else
            acc_next = term;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule
